// ===== rtl/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular deque.
// Used by circular_deque and its testbench; depends on nothing.
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VALUE_W       = 32;
    localparam int OCC_W         = 4;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int M_DATA_W      = ((VALUE_W + OCC_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

endpackage

// ===== rtl/cdq_ram.sv =====
// cdq_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/circular_deque.sv =====
// circular_deque: fixed-capacity deque over a ring RAM (top level).
// Depends on cdq_pkg and cdq_ram.
//
//  channel | tvalid/tready | tuser          | tdata
//  s_      | request in    | req_type [1:0] | push_value [31:0]
//  m_      | result out    | status [1:0]   | popped_value [31:0], occupancy [35:32]
//
// Each request is accepted (index update, RAM write or read issue), then held as
// pending while the RAM's registered read completes, before the result register loads.
// No new request is taken while one is pending; the pending flag, not the RAM read port, sets this.
// Synchronous active-low reset empties the deque; RAM contents are not cleared.
// A stalled result holds in the output register; the next request waits for it.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdq_pkg::VALUE_W-1:0]   s_tdata,   // push_value
    input  logic [cdq_pkg::REQ_W-1:0]     s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata,   // popped_value, occupancy, zero pad
    output logic [cdq_pkg::STATUS_W-1:0]  m_tuser    // status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam int PAD_W = cdq_pkg::M_DATA_W - cdq_pkg::VALUE_W - cdq_pkg::OCC_W;

    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;

    logic                          pend_reg;
    logic                          pend_pop_ok_reg, pop_ok;
    cdq_pkg::status_t              pend_status_reg, status_next;
    logic [cdq_pkg::OCC_W-1:0]     pend_occ_reg;

    logic                          m_valid_reg;
    cdq_pkg::status_t              m_status_reg;
    logic [cdq_pkg::VALUE_W-1:0]   m_popped_reg;
    logic [cdq_pkg::OCC_W-1:0]     m_occ_reg;

    logic                          accept;
    logic                          out_free;
    logic                          is_empty, is_full;
    cdq_pkg::req_t                 req;
    logic                          ram_we, ram_re;
    logic [IW-1:0]                 ram_waddr, ram_raddr;
    logic [cdq_pkg::VALUE_W-1:0]   ram_rdata;

    function automatic logic [IW-1:0] idx_up(input logic [IW-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_down(input logic [IW-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !pend_reg && out_free;
    assign accept   = s_tvalid && s_tready;
    assign req      = cdq_pkg::req_t'(s_tuser);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        status_next = cdq_pkg::ST_DONE;
        pop_ok      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = front_reg;
        unique case (req)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
                if (is_full) begin
                    status_next = cdq_pkg::ST_OVERFLOW;
                end else begin
                    ram_we     = accept;
                    count_next = count_reg + 1'b1;
                    if (is_empty) begin
                        front_next = '0;
                        rear_next  = '0;
                        ram_waddr  = '0;
                    end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
                        front_next = idx_down(front_reg);
                        ram_waddr  = front_next;
                    end else begin
                        rear_next = idx_up(rear_reg);
                        ram_waddr = rear_next;
                    end
                end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
                if (is_empty) begin
                    status_next = cdq_pkg::ST_EMPTY;
                end else begin
                    pop_ok     = 1'b1;
                    ram_re     = accept;
                    ram_raddr  = (req == cdq_pkg::REQ_POP_FRONT) ? front_reg : rear_reg;
                    count_next = count_reg - 1'b1;
                    if (front_reg == rear_reg) begin
                        front_next = '0;
                        rear_next  = '0;
                    end else if (req == cdq_pkg::REQ_POP_FRONT) begin
                        front_next = idx_up(front_reg);
                    end else begin
                        rear_next = idx_down(rear_reg);
                    end
                end
            end
            default: begin
                status_next = cdq_pkg::ST_DONE;
            end
        endcase
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            rear_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= accept;
            if (accept) begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
            end
            // pend_reg only rises when the output side was free, so it always loads here
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg <= status_next;
            pend_pop_ok_reg <= pop_ok;
            pend_occ_reg    <= cdq_pkg::OCC_W'(count_next);
        end
        if (pend_reg) begin
            m_status_reg <= pend_status_reg;
            m_popped_reg <= pend_pop_ok_reg ? ram_rdata : '0;
            m_occ_reg    <= pend_occ_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_occ_reg, m_popped_reg};

endmodule
